FILE: design/json_token_lexer_core_macros.svh
// ---------------------------------------------------------------------------
// json token lexer assertion macros
// concurrent assertion helpers, empty for synthesis
// ---------------------------------------------------------------------------
`ifndef JSON_TOKEN_LEXER_CORE_MACROS_SVH
`define JSON_TOKEN_LEXER_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define JTL_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jtl assertion failed");

`define JTL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jtl assertion failed");

`else

`define JTL_ASSERT_SAME(label, clk, rst, ante, cons)

`define JTL_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: design/jtl_pkg.sv
// ---------------------------------------------------------------------------
// jtl_pkg
// shared constants and types of the json token lexer
// ---------------------------------------------------------------------------
package jtl_pkg;

  localparam int TOKEN_BYTES_DEF = 512;

  localparam logic [3:0] EV_TEXT      = 4'd0;
  localparam logic [3:0] EV_OBJ_OPEN  = 4'd1;
  localparam logic [3:0] EV_OBJ_CLOSE = 4'd2;
  localparam logic [3:0] EV_COLON     = 4'd3;
  localparam logic [3:0] EV_COMMA     = 4'd4;
  localparam logic [3:0] EV_STR_DONE  = 4'd5;
  localparam logic [3:0] EV_UNUM_DONE = 4'd6;
  localparam logic [3:0] EV_NNUM_DONE = 4'd7;
  localparam logic [3:0] EV_END       = 4'd8;
  localparam logic [3:0] EV_ERROR     = 4'd9;

  localparam logic [3:0] ERR_NONE       = 4'd0;
  localparam logic [3:0] ERR_CTRL_CHAR  = 4'd1;
  localparam logic [3:0] ERR_OPEN_ESC   = 4'd2;
  localparam logic [3:0] ERR_BAD_UNI    = 4'd3;
  localparam logic [3:0] ERR_SURROGATE  = 4'd4;
  localparam logic [3:0] ERR_BAD_ESC    = 4'd5;
  localparam logic [3:0] ERR_OPEN_STR   = 4'd6;
  localparam logic [3:0] ERR_BAD_NUM    = 4'd7;
  localparam logic [3:0] ERR_FRAC_EXP   = 4'd8;
  localparam logic [3:0] ERR_TOO_LONG   = 4'd9;
  localparam logic [3:0] ERR_UNEXPECTED = 4'd10;

  typedef struct packed {
    logic [3:0] err;
    logic [7:0] data;
    logic [3:0] ev;
  } result_t;

endpackage

FILE: design/json_token_lexer_core.sv
// ---------------------------------------------------------------------------
// json_token_lexer_core
// byte-wide json lexer: punctuation, unescaped string text, integers
// ---------------------------------------------------------------------------
// channel  dir  fields (low bit first)
// s_axis   in   tdata: in_byte[7:0]
// m_axis   out  tdata: event_res[3:0], data_byte[11:4], error_code[15:12];
//               tlast: last_of_run
//
// one byte is lexed per cycle while s_tready is high; each byte gives 0 to 3 transactions
// a 3-entry result buffer drains one transaction per cycle while m_tready is high
// s_tready is high when the buffer is empty or its last entry leaves this cycle
// a byte that gives more than one result blocks input until the last of its results leaves
// rst clears lexer state and empties the buffer
// ---------------------------------------------------------------------------
`include "json_token_lexer_core_macros.svh"

module json_token_lexer_core #(
  parameter int TOKEN_BYTES = jtl_pkg::TOKEN_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // in_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // event_res, data_byte, error_code
  output logic        m_tlast    // last_of_run
);
  import jtl_pkg::*;

  localparam int CNT_W = $clog2(TOKEN_BYTES);
  localparam logic [CNT_W:0] TOK_LIM = (CNT_W + 1)'(TOKEN_BYTES);

  typedef enum logic [2:0] {
    M_IDLE, M_STR, M_ESC, M_HEX, M_SIGN, M_DIGITS, M_HALT
  } mode_t;

  typedef struct packed {
    mode_t             mode;
    logic [15:0]       hexv;
    logic [1:0]        hexcnt;
    logic [CNT_W-1:0]  tc;
    logic              neg;
    logic              fdz;
    logic [1:0]        n;
    result_t [2:0]     res;
  } lex_t;

  lex_t             cur;
  lex_t             nxt;
  result_t [2:0]    buf_q;
  logic [2:0]       last_q;
  logic [1:0]       cnt;
  logic             s_acc;
  logic             m_acc;

  function automatic lex_t f_push(lex_t s, logic [3:0] ev, logic [7:0] d, logic [3:0] e);
    lex_t r;
    r = s;
    if (r.n != 2'd3) begin
      r.res[r.n] = '{err: e, data: d, ev: ev};
      r.n = r.n + 2'd1;
    end
    return r;
  endfunction

  function automatic lex_t f_fail(lex_t s, logic [3:0] code);
    lex_t r;
    r = f_push(s, EV_ERROR, 8'd0, code);
    r.mode = M_HALT;
    return r;
  endfunction

  function automatic lex_t f_text(lex_t s, logic [7:0] b);
    lex_t r;
    if (({1'b0, s.tc} + 1'b1) >= TOK_LIM) begin
      r = f_fail(s, ERR_TOO_LONG);
    end else begin
      r = f_push(s, EV_TEXT, b, ERR_NONE);
      r.tc = r.tc + 1'b1;
    end
    return r;
  endfunction

  function automatic logic f_digit(logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic lex_t f_idle(lex_t s, logic [7:0] b);
    lex_t r;
    r = s;
    r.mode = M_IDLE;
    if (b == 8'h00) begin
      r = f_push(r, EV_END, 8'd0, ERR_NONE);
    end else if ((b >= 8'h09 && b <= 8'h0D) || b == 8'h20) begin
      r.mode = M_IDLE;
    end else if (b == 8'h7B) begin
      r = f_push(r, EV_OBJ_OPEN, 8'd0, ERR_NONE);
    end else if (b == 8'h7D) begin
      r = f_push(r, EV_OBJ_CLOSE, 8'd0, ERR_NONE);
    end else if (b == 8'h3A) begin
      r = f_push(r, EV_COLON, 8'd0, ERR_NONE);
    end else if (b == 8'h2C) begin
      r = f_push(r, EV_COMMA, 8'd0, ERR_NONE);
    end else if (b == 8'h22) begin
      r.tc = '0;
      r.mode = M_STR;
    end else if (b == 8'h2D) begin
      r.tc = '0;
      r.neg = 1'b1;
      r.fdz = 1'b0;
      r.mode = M_SIGN;
      r = f_text(r, b);
    end else if (f_digit(b)) begin
      r.tc = '0;
      r.neg = 1'b0;
      r.fdz = (b == 8'h30);
      r.mode = M_DIGITS;
      r = f_text(r, b);
    end else begin
      r = f_fail(r, ERR_UNEXPECTED);
    end
    return r;
  endfunction

  function automatic lex_t f_code_point(lex_t s, logic [15:0] cp);
    lex_t r;
    r = s;
    if (cp <= 16'h007F) begin
      r = f_text(r, cp[7:0]);
    end else if (cp <= 16'h07FF) begin
      r = f_text(r, {3'b110, cp[10:6]});
      if (r.mode != M_HALT) r = f_text(r, {2'b10, cp[5:0]});
    end else if (cp >= 16'hD800 && cp <= 16'hDFFF) begin
      r = f_fail(r, ERR_SURROGATE);
    end else begin
      r = f_text(r, {4'b1110, cp[15:12]});
      if (r.mode != M_HALT) r = f_text(r, {2'b10, cp[11:6]});
      if (r.mode != M_HALT) r = f_text(r, {2'b10, cp[5:0]});
    end
    return r;
  endfunction

  function automatic lex_t f_escape(lex_t s, logic [7:0] b);
    lex_t r;
    r = s;
    r.mode = M_STR;
    case (b)
      8'h22, 8'h5C, 8'h2F: r = f_text(r, b);
      8'h62: r = f_text(r, 8'h08);
      8'h66: r = f_text(r, 8'h0C);
      8'h6E: r = f_text(r, 8'h0A);
      8'h72: r = f_text(r, 8'h0D);
      8'h74: r = f_text(r, 8'h09);
      8'h75: begin
        r.hexv = '0;
        r.hexcnt = '0;
        r.mode = M_HEX;
      end
      8'h00: r = f_fail(r, ERR_OPEN_ESC);
      default: r = f_fail(r, ERR_BAD_ESC);
    endcase
    return r;
  endfunction

  function automatic lex_t f_hex(lex_t s, logic [7:0] b);
    lex_t       r;
    logic [3:0] d;
    logic       ok;
    r = s;
    ok = 1'b1;
    d = '0;
    if (f_digit(b)) begin
      d = b[3:0];
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      d = b[3:0] + 4'd9;
    end else begin
      ok = 1'b0;
    end
    if (!ok) begin
      r = f_fail(r, ERR_BAD_UNI);
    end else begin
      r.hexv = {r.hexv[11:0], d};
      if (r.hexcnt == 2'd3) begin
        r.hexcnt = '0;
        r.mode = M_STR;
        r = f_code_point(r, r.hexv);
      end else begin
        r.hexcnt = r.hexcnt + 2'd1;
      end
    end
    return r;
  endfunction

  always_comb begin
    nxt = cur;
    nxt.n = '0;
    nxt.res = '0;
    case (cur.mode)
      M_HALT: begin
        if (s_tdata == 8'h00) begin
          nxt = f_push(nxt, EV_END, 8'd0, ERR_NONE);
          nxt.mode = M_IDLE;
        end
      end
      M_STR: begin
        if (s_tdata == 8'h00) begin
          nxt = f_fail(nxt, ERR_OPEN_STR);
        end else if (s_tdata == 8'h22) begin
          nxt = f_push(nxt, EV_STR_DONE, 8'd0, ERR_NONE);
          nxt.mode = M_IDLE;
        end else if (s_tdata < 8'h20) begin
          nxt = f_fail(nxt, ERR_CTRL_CHAR);
        end else if (s_tdata == 8'h5C) begin
          nxt.mode = M_ESC;
        end else begin
          nxt = f_text(nxt, s_tdata);
        end
      end
      M_ESC: nxt = f_escape(nxt, s_tdata);
      M_HEX: nxt = f_hex(nxt, s_tdata);
      M_SIGN: begin
        if (f_digit(s_tdata)) begin
          nxt.fdz = (s_tdata == 8'h30);
          nxt.mode = M_DIGITS;
          nxt = f_text(nxt, s_tdata);
        end else begin
          nxt = f_fail(nxt, ERR_BAD_NUM);
        end
      end
      M_DIGITS: begin
        if (f_digit(s_tdata)) begin
          if (cur.fdz) nxt = f_fail(nxt, ERR_BAD_NUM);
          else nxt = f_text(nxt, s_tdata);
        end else if (s_tdata == 8'h2E || s_tdata == 8'h65 || s_tdata == 8'h45) begin
          nxt = f_fail(nxt, ERR_FRAC_EXP);
        end else begin
          nxt = f_push(nxt, cur.neg ? EV_NNUM_DONE : EV_UNUM_DONE, 8'd0, ERR_NONE);
          nxt = f_idle(nxt, s_tdata);
        end
      end
      default: nxt = f_idle(nxt, s_tdata);
    endcase
    if (s_tdata == 8'h00 && nxt.mode == M_HALT) nxt.mode = M_IDLE;
  end

  assign m_acc    = m_tvalid && m_tready;
  assign s_tready = (cnt == 2'd0) || (cnt == 2'd1 && m_tready);
  assign s_acc    = s_tvalid && s_tready;
  assign m_tvalid = (cnt != 2'd0);
  assign m_tdata  = buf_q[0];
  assign m_tlast  = last_q[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.mode   <= M_IDLE;
      cur.hexv   <= '0;
      cur.hexcnt <= '0;
      cur.tc     <= '0;
      cur.neg    <= 1'b0;
      cur.fdz    <= 1'b0;
      cur.n      <= '0;
      cur.res    <= '0;
      cnt        <= '0;
    end else if (s_acc) begin
      cur.mode   <= nxt.mode;
      cur.hexv   <= nxt.hexv;
      cur.hexcnt <= nxt.hexcnt;
      cur.tc     <= nxt.tc;
      cur.neg    <= nxt.neg;
      cur.fdz    <= nxt.fdz;
      cnt        <= nxt.n;
    end else if (m_acc) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      buf_q     <= nxt.res;
      last_q[0] <= (nxt.n == 2'd1);
      last_q[1] <= (nxt.n == 2'd2);
      last_q[2] <= (nxt.n == 2'd3);
    end else if (m_acc) begin
      buf_q[0]  <= buf_q[1];
      buf_q[1]  <= buf_q[2];
      last_q[0] <= last_q[1];
      last_q[1] <= last_q[2];
    end
  end

  `JTL_ASSERT_SAME(a_single_is_last, clk, rst, cnt == 2'd1, last_q[0])
  `JTL_ASSERT_NEXT(a_halt_silent, clk, rst,
                   s_acc && cur.mode == M_HALT && s_tdata != 8'h00, !m_tvalid)
  `JTL_ASSERT_NEXT(a_end_to_idle, clk, rst, s_acc && s_tdata == 8'h00, cur.mode == M_IDLE)
  `JTL_ASSERT_SAME(a_no_overrun, clk, rst, s_acc, (cnt == 2'd0) || (cnt == 2'd1 && m_acc))

endmodule
